// ===== hw/rtl/rate_group_task_dispatcher_assert.svh =====
// Assertion macros for the rate group task dispatcher.
// Used by the top level; depends only on a clk and rst in scope.
`ifndef RATE_GROUP_TASK_DISPATCHER_ASSERT_SVH
`define RATE_GROUP_TASK_DISPATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rgtd_pkg.sv =====
// Shared types and constants of the rate group task dispatcher.
// No dependencies; used by the top level.
`default_nettype none

package rgtd_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

  localparam logic [19:0] PERIOD_RESET = 20'd10000;
  localparam logic [9:0]  WINDOW_RESET = 10'd100;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NO_SPACE = 3'd3;
  localparam logic [2:0] ST_BAD_TASK = 3'd4;

  localparam int          PCT_NUM_W = 55;
  localparam logic [6:0]  PCT_FULL  = 7'd100;

  typedef struct packed {
    logic [31:0] last_us;
    logic [47:0] sum_us;
    logic [31:0] runs;
    logic [31:0] peak_us;
  } stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [3:0]  task_slot;
    logic        last;
    logic        due_valid;
    logic        on_time;
    logic [6:0]  load_pct;
    logic [31:0] overrun_count;
    logic [3:0]  worst_task;
    logic        worst_valid;
    logic [31:0] task_max_us;
    logic [31:0] task_runs;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgtd_if.sv =====
// Command and result channel interfaces of the rate group task dispatcher.
// Each carries valid, ready and the payload fields of one word.
`default_nettype none

interface rgtd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] divider;
  logic [15:0] phase;
  logic [3:0]  task_id;
  logic [31:0] elapsed_us;
  logic [31:0] busy_us;

  modport source (output valid, mode, divider, phase, task_id, elapsed_us, busy_us,
                  input ready);
  modport sink (input valid, mode, divider, phase, task_id, elapsed_us, busy_us,
                output ready);
endinterface

interface rgtd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [3:0]  task_slot;
  logic        last;
  logic        due_valid;
  logic        on_time;
  logic [6:0]  load_pct;
  logic [31:0] overrun_count;
  logic [3:0]  worst_task;
  logic        worst_valid;
  logic [31:0] task_max_us;
  logic [31:0] task_runs;

  modport source (output valid, kind, status, task_slot, last, due_valid, on_time,
                  load_pct, overrun_count, worst_task, worst_valid, task_max_us,
                  task_runs, input ready);
  modport sink (input valid, kind, status, task_slot, last, due_valid, on_time,
                load_pct, overrun_count, worst_task, worst_valid, task_max_us,
                task_runs, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rate_group_task_dispatcher.sv =====
// Rate group task dispatcher: one restoring divider shared by the due test and the load percent.
// Tick start walks the task table; tick end walks it only after an overrun. Each task step divides the
// tick counter, one remainder bit per cycle; a closing window adds a division for the percent.
// One command word is in flight at a time; a result word waits in the output register.
// Synchronous reset clears control state, counters and statistic valid bits; no clearing pass.
// Depends on rgtd_pkg, rgtd_if.sv and rate_group_task_dispatcher_assert.svh.
`default_nettype none

module rate_group_task_dispatcher #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rgtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgtd_pkg::CFG_DATA_W-1:0] cfg_data,
  rgtd_cmd_if.sink                       cmd,
  rgtd_rsp_if.source                     rsp
);
  import rgtd_pkg::*;

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int NUM_W  = (TICK_BITS > PCT_NUM_W) ? TICK_BITS : PCT_NUM_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_REP   = 4'd1;
  localparam logic [3:0] S_WNEXT = 4'd2;
  localparam logic [3:0] S_WLOAD = 4'd3;
  localparam logic [3:0] S_WDIV  = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_TACC  = 4'd6;
  localparam logic [3:0] S_TMUL  = 4'd7;
  localparam logic [3:0] S_TLOAD = 4'd8;
  localparam logic [3:0] S_TDIV  = 4'd9;
  localparam logic [3:0] S_TPCT  = 4'd10;
  localparam logic [3:0] S_TOUT  = 4'd11;

  logic [3:0]            state;
  logic [19:0]           period;
  logic [9:0]            window;
  logic [CNT_W-1:0]      task_count;
  logic [TICK_BITS-1:0]  tick_counter;
  logic [47:0]           busy_accum;
  logic [9:0]            window_count;
  logic [6:0]            load_value;
  logic [31:0]           overrun_total;

  logic [15:0]           task_rate_div [MAX_TASKS];
  logic [15:0]           task_phase [MAX_TASKS];
  stat_t                 stats [MAX_TASKS];
  logic [MAX_TASKS-1:0]  stat_valid;
  logic [15:0]           rd_div;
  logic [15:0]           rd_phase;
  stat_t                 rd_stat;
  logic [IDX_W-1:0]      rd_addr;

  logic [1:0]            mode_r;
  logic [3:0]            id_r;
  logic                  rep_bad;
  logic [31:0]           elapsed_r;
  logic [31:0]           busy_r;
  logic                  overran;
  logic [CNT_W-1:0]      wk_idx;
  logic                  pend_valid;
  logic [3:0]            pend_idx;
  logic [31:0]           worst_time;
  logic [3:0]            worst_idx;
  logic                  worst_valid;
  logic [47:0]           sum_r;
  logic [9:0]            wc_r;
  logic [PCT_NUM_W-1:0]  prod_r;
  logic [29:0]           win_r;

  logic [NUM_W-1:0]      dv_num;
  logic [31:0]           dv_rem;
  logic [31:0]           dv_den;
  logic [STEP_W-1:0]     dv_cnt;
  logic [7:0]            dv_q;
  logic                  dv_sat;
  logic [32:0]           rem_sh;
  logic                  dv_ge;

  logic                  can_emit;
  logic                  acc;
  logic                  emit;
  res_t                  res;
  logic [2:0]            add_status;
  stat_t                 cur_stat;
  stat_t                 new_stat;
  logic [48:0]           total_sum;
  logic [48:0]           accum_sum;
  logic [47:0]           accum_sat;
  logic [9:0]            wc1;
  logic                  walk_done;
  logic                  due;
  logic [31:0]           due_last;

  assign can_emit  = !rsp.valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && can_emit;
  assign acc       = cmd.valid && cmd.ready;
  assign rd_addr   = (state == S_IDLE) ? IDX_W'(cmd.task_id) :
                     (state == S_REP)  ? IDX_W'(id_r) : wk_idx[IDX_W-1:0];

  assign rem_sh    = {dv_rem, dv_num[NUM_W-1]};
  assign dv_ge     = rem_sh >= {1'b0, dv_den};
  assign walk_done = wk_idx >= task_count;
  assign due       = (rd_div != 16'd0) && (dv_rem == 32'(rd_phase));
  assign cur_stat  = stat_valid[rd_addr] ? rd_stat : '0;
  assign due_last  = cur_stat.last_us;
  assign total_sum = {1'b0, cur_stat.sum_us} + 49'(elapsed_r);
  assign accum_sum = {1'b0, busy_accum} + 49'(busy_r);
  assign accum_sat = accum_sum[48] ? '1 : accum_sum[47:0];
  assign wc1       = window_count + 10'd1;

  always_comb begin
    new_stat.last_us  = elapsed_r;
    new_stat.sum_us   = total_sum[48] ? '1 : total_sum[47:0];
    new_stat.runs     = (cur_stat.runs == '1) ? cur_stat.runs : cur_stat.runs + 32'd1;
    new_stat.peak_us  = (elapsed_r > cur_stat.peak_us) ? elapsed_r : cur_stat.peak_us;
  end

  always_comb begin
    priority if (cmd.divider == 16'd0) begin
      add_status = ST_INVALID;
    end else if (cmd.phase >= cmd.divider) begin
      add_status = ST_RANGE;
    end else if (32'(task_count) >= 32'(MAX_TASKS)) begin
      add_status = ST_NO_SPACE;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    emit = 1'b0;
    res  = '0;
    unique case (state)
      S_IDLE: begin
        if (acc && cmd.mode == MODE_ADD) begin
          emit       = 1'b1;
          res.kind   = MODE_ADD;
          res.status = add_status;
          if (add_status == ST_OK) res.task_slot = 4'(task_count);
        end
      end
      S_REP: begin
        emit     = can_emit;
        res.kind = MODE_REPORT;
        if (rep_bad) begin
          res.status = ST_BAD_TASK;
        end else begin
          res.task_slot   = id_r;
          res.task_max_us = new_stat.peak_us;
          res.task_runs   = new_stat.runs;
        end
      end
      S_WNEXT: begin
        if (mode_r == MODE_START && walk_done) begin
          emit          = can_emit;
          res.kind      = MODE_START;
          res.last      = 1'b1;
          res.due_valid = pend_valid;
          res.task_slot = pend_valid ? pend_idx : 4'd0;
        end
      end
      S_WCHK: begin
        if (mode_r == MODE_START && due && pend_valid) begin
          emit          = can_emit;
          res.kind      = MODE_START;
          res.due_valid = 1'b1;
          res.task_slot = pend_idx;
        end
      end
      S_TOUT: begin
        emit              = can_emit;
        res.kind          = MODE_END;
        res.on_time       = !overran;
        res.load_pct      = load_value;
        res.overrun_count = overrun_total;
        res.worst_task    = worst_valid ? worst_idx : 4'd0;
        res.worst_valid   = worst_valid;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_div   <= task_rate_div[rd_addr];
    rd_phase <= task_phase[rd_addr];
    rd_stat  <= stats[rd_addr];
    if (acc && cmd.mode == MODE_ADD && add_status == ST_OK) begin
      task_rate_div[task_count[IDX_W-1:0]] <= cmd.divider;
      task_phase[task_count[IDX_W-1:0]]    <= cmd.phase;
    end
    if (state == S_REP && can_emit && !rep_bad) begin
      stats[rd_addr] <= new_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (emit) begin
      rsp.kind          <= res.kind;
      rsp.status        <= res.status;
      rsp.task_slot     <= res.task_slot;
      rsp.last          <= res.last;
      rsp.due_valid     <= res.due_valid;
      rsp.on_time       <= res.on_time;
      rsp.load_pct      <= res.load_pct;
      rsp.overrun_count <= res.overrun_count;
      rsp.worst_task    <= res.worst_task;
      rsp.worst_valid   <= res.worst_valid;
      rsp.task_max_us   <= res.task_max_us;
      rsp.task_runs     <= res.task_runs;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WDIV || state == S_TDIV) begin
      dv_rem <= dv_ge ? 32'(rem_sh - {1'b0, dv_den}) : rem_sh[31:0];
      dv_num <= dv_num << 1;
      dv_q   <= {dv_q[6:0], dv_ge};
      dv_sat <= dv_sat | dv_q[7];
      dv_cnt <= dv_cnt - STEP_W'(1);
    end else if (state == S_WLOAD) begin
      dv_num <= NUM_W'(tick_counter) << (NUM_W - TICK_BITS);
      dv_den <= 32'(rd_div);
      dv_rem <= '0;
      dv_q   <= '0;
      dv_sat <= 1'b0;
      dv_cnt <= STEP_W'(TICK_BITS);
    end else if (state == S_TLOAD) begin
      dv_num <= NUM_W'(prod_r) << (NUM_W - PCT_NUM_W);
      dv_den <= (win_r == 30'd0) ? 32'd1 : 32'(win_r);
      dv_rem <= '0;
      dv_q   <= '0;
      dv_sat <= 1'b0;
      dv_cnt <= STEP_W'(PCT_NUM_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      period        <= PERIOD_RESET;
      window        <= WINDOW_RESET;
      task_count    <= '0;
      tick_counter  <= '0;
      busy_accum    <= '0;
      window_count  <= '0;
      load_value    <= '0;
      overrun_total <= '0;
      stat_valid    <= '0;
      pend_valid    <= 1'b0;
      worst_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_PERIOD) period <= cfg_data;
        if (cfg_index == REG_WINDOW) window <= cfg_data[9:0];
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            mode_r      <= cmd.mode;
            id_r        <= cmd.task_id;
            rep_bad     <= 32'(cmd.task_id) >= 32'(task_count);
            elapsed_r   <= cmd.elapsed_us;
            busy_r      <= cmd.busy_us;
            overran     <= cmd.busy_us > 32'(period);
            wk_idx      <= '0;
            pend_valid  <= 1'b0;
            worst_valid <= 1'b0;
            worst_time  <= '0;
            unique case (cmd.mode)
              MODE_ADD: begin
                if (add_status == ST_OK) task_count <= task_count + CNT_W'(1);
              end
              MODE_START: state <= S_WNEXT;
              MODE_REPORT: state <= S_REP;
              MODE_END: state <= (cmd.busy_us > 32'(period)) ? S_WNEXT : S_TACC;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_REP: begin
          if (can_emit) begin
            if (!rep_bad) stat_valid[rd_addr] <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WNEXT: begin
          if (!walk_done) begin
            state <= S_WLOAD;
          end else if (mode_r == MODE_END) begin
            state <= S_TACC;
          end else if (can_emit) begin
            state <= S_IDLE;
          end
        end
        S_WLOAD: state <= S_WDIV;
        S_WDIV: begin
          if (dv_cnt == STEP_W'(1)) state <= S_WCHK;
        end
        S_WCHK: begin
          if (mode_r == MODE_START) begin
            if (!(due && pend_valid) || can_emit) begin
              if (due) begin
                pend_valid <= 1'b1;
                pend_idx   <= 4'(wk_idx);
              end
              wk_idx <= wk_idx + CNT_W'(1);
              state  <= S_WNEXT;
            end
          end else begin
            if (due && due_last > worst_time) begin
              worst_time  <= due_last;
              worst_idx   <= 4'(wk_idx);
              worst_valid <= 1'b1;
            end
            wk_idx <= wk_idx + CNT_W'(1);
            state  <= S_WNEXT;
          end
        end
        S_TACC: begin
          if (overran && overrun_total != '1) overrun_total <= overrun_total + 32'd1;
          sum_r <= accum_sat;
          wc_r  <= wc1;
          if (wc1 >= window) begin
            busy_accum   <= '0;
            window_count <= '0;
            state        <= S_TMUL;
          end else begin
            busy_accum   <= accum_sat;
            window_count <= wc1;
            state        <= S_TOUT;
          end
        end
        S_TMUL: begin
          prod_r <= PCT_NUM_W'(sum_r) * PCT_NUM_W'(PCT_FULL);
          win_r  <= 30'(period) * 30'(wc_r);
          state  <= S_TLOAD;
        end
        S_TLOAD: state <= S_TDIV;
        S_TDIV: begin
          if (dv_cnt == STEP_W'(1)) state <= S_TPCT;
        end
        S_TPCT: begin
          load_value <= (dv_sat || dv_q > 8'(PCT_FULL)) ? PCT_FULL : dv_q[6:0];
          state      <= S_TOUT;
        end
        S_TOUT: begin
          if (can_emit) begin
            tick_counter <= tick_counter + TICK_BITS'(1);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "rate_group_task_dispatcher_assert.svh"

  `RGTD_ASSERT_NOW(a_count_bound, 1'b1, 32'(task_count) <= 32'(MAX_TASKS), "task count overflow")
  `RGTD_ASSERT_NOW(a_load_bound, 1'b1, load_value <= PCT_FULL, "load percent above full")
  `RGTD_ASSERT_NOW(a_start_due, rsp.valid && rsp.kind == MODE_START && !rsp.last,
    rsp.due_valid, "non-final tick start word without a due task")
  `RGTD_ASSERT_NEXT(a_busy_after_cmd, acc && cmd.mode != MODE_ADD, state != S_IDLE,
    "sequencer idle right after a multi-cycle command")

endmodule

`default_nettype wire
